// ===== design/tlbt_pkg.sv =====
// shared types and constants for the tlb / page table / lru translator
// no dependencies
package tlbt_pkg;
   localparam int PageBits  = 8;
   localparam int FrameBits = 8;
   localparam int CntBits   = 9;

   typedef logic [PageBits-1:0]  page_type;
   typedef logic [FrameBits-1:0] frame_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_RESOLVE, ST_OWNER, ST_TOUCH, ST_DONE
   } state_type;

   typedef enum logic [0:0] {
      REG_NUM_FRAMES = 1'b0
   } reg_index_type;
endpackage

// ===== design/tlb_page_table_lru_translator_core.sv =====
// top level: translator with fifo tlb, page table and lru chain of cells
// depends on tlbt_pkg and tlbt_lru_cell
// tlb hit: ST_LOOK, ST_TOUCH, then ST_DONE, where rsp_valid is shown; busy is high in every state but ST_IDLE
// tlb miss: ST_LOOK, ST_RESOLVE, ST_OWNER, ST_TOUCH, then ST_DONE; a new request is taken only back in ST_IDLE
// reset clears counts and page valid bits; entries past the counts are never read
// results cannot be stalled: rsp_valid is a single-cycle strobe
module tlb_page_table_lru_translator_core #(
   parameter int TLB_ENTRIES = 16,
   parameter int MAX_FRAMES  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_virtual_address,
   output logic        rsp_valid,
   output logic [15:0] rsp_physical_address,
   output logic        rsp_tlb_hit,
   output logic        rsp_page_fault,
   output logic        rsp_evicted,
   output logic [7:0]  rsp_evicted_page,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tlbt_pkg::*;
   localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int TC = $clog2(TLB_ENTRIES + 1);
   localparam int PageCount = 256;

   state_type state_ff, state_in;
   logic [CntBits-1:0] num_frames_ff;
   logic [CntBits-1:0] used_ff;
   logic [TC-1:0] tlb_count_ff;
   logic [TW-1:0] tlb_oldest_ff;
   page_type  tlb_page_ff  [TLB_ENTRIES];
   frame_type tlb_frame_ff [TLB_ENTRIES];
   logic [PageCount-1:0] page_valid_ff;
   frame_type page_frame_mem [PageCount];
   page_type  owner_mem [MAX_FRAMES];
   frame_type pf_rd_ff;
   page_type  own_rd_ff;

   page_type  page_ff;
   logic [7:0] offset_ff;
   frame_type frame_ff;
   logic hit_ff, fault_ff, evict_ff;
   page_type victim_ff;

   // config port
   logic wr_en;
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr == {REG_NUM_FRAMES, 1'b0}) ? {23'd0, num_frames_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_frames_ff <= 9'd256;
      end else if (wr_en && csr_paddr == {REG_NUM_FRAMES, 1'b0}) begin
         num_frames_ff <= csr_pwdata[CntBits-1:0];
      end
   end

   // effective frame limit
   logic [CntBits-1:0] limit;
   always_comb begin
      limit = num_frames_ff;
      if (limit > CntBits'(MAX_FRAMES)) limit = CntBits'(MAX_FRAMES);
      if (limit == '0) limit = CntBits'(1);
   end

   // tlb compare, oldest-first priority
   logic tlb_match;
   frame_type tlb_match_frame;
   always_comb begin
      int kk;
      tlb_match = 1'b0;
      tlb_match_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         kk = int'(tlb_oldest_ff) + i;
         if (kk >= TLB_ENTRIES) kk = kk - TLB_ENTRIES;
         if (TC'(i) < tlb_count_ff && tlb_page_ff[TW'(kk)] == page_ff) begin
            tlb_match = 1'b1;
            tlb_match_frame = tlb_frame_ff[TW'(kk)];
         end
      end
   end

   // lru chain
   frame_type cell_val [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] shift_vec, load_vec;
   logic [MAX_FRAMES-1:0] match_vec, pre_vec;
   logic touch_en, append_en;
   logic [CntBits-1:0] tail_idx;
   frame_type cell_load;

   // an append loads the fresh frame number, a touch reloads the touched frame
   assign cell_load = append_en ? FrameBits'(used_ff) : frame_ff;

   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match_vec[i] = (CntBits'(i) < used_ff) && (cell_val[i] == frame_ff);
      end
      // pre_vec[i]: some match at index <= i
      pre_vec[0] = match_vec[0];
      for (int i = 1; i < MAX_FRAMES; i++) pre_vec[i] = pre_vec[i-1] | match_vec[i];
      tail_idx = used_ff - CntBits'(1);
      for (int i = 0; i < MAX_FRAMES; i++) begin
         shift_vec[i] = touch_en && pre_vec[i] && (CntBits'(i) < tail_idx);
         load_vec[i]  = (touch_en && pre_vec[i] && CntBits'(i) == tail_idx) ||
                        (append_en && CntBits'(i) == used_ff);
      end
   end

   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_lru
      tlbt_lru_cell u_cell (
         .clock(clock), .reset(reset),
         .shift_en(shift_vec[g]), .load_en(load_vec[g]),
         .load_value(cell_load),
         .next_value(cell_val[(g + 1) % MAX_FRAMES]),
         .value(cell_val[g])
      );
   end

   // fsm
   logic pt_write, tlb_insert, owner_write, drop_victim, used_inc;
   frame_type frame_in;
   logic hit_in, fault_in, evict_in;
   page_type victim_in;

   always_comb begin
      state_in = state_ff;
      frame_in = frame_ff;
      hit_in = hit_ff; fault_in = fault_ff; evict_in = evict_ff; victim_in = victim_ff;
      pt_write = 1'b0; tlb_insert = 1'b0; owner_write = 1'b0;
      drop_victim = 1'b0; used_inc = 1'b0; touch_en = 1'b0; append_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            hit_in = tlb_match; fault_in = 1'b0; evict_in = 1'b0; victim_in = '0;
            frame_in = tlb_match_frame;
            state_in = tlb_match ? ST_TOUCH : ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (page_valid_ff[page_ff]) begin
               frame_in = pf_rd_ff;
               state_in = ST_OWNER;
            end else begin
               fault_in = 1'b1;
               if (used_ff < limit) begin
                  frame_in = FrameBits'(used_ff);
                  append_en = 1'b1;
                  used_inc = 1'b1;
               end else begin
                  frame_in = cell_val[0];
                  evict_in = 1'b1;
               end
               state_in = ST_OWNER;
            end
         end
         ST_OWNER: begin
            // owner read of frame_ff is ready here
            if (fault_ff) begin
               if (evict_ff) begin
                  victim_in = own_rd_ff;
                  drop_victim = 1'b1;
               end
               pt_write = 1'b1;
               owner_write = 1'b1;
            end
            tlb_insert = 1'b1;
            state_in = ST_TOUCH;
         end
         ST_TOUCH: begin
            touch_en = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a page that still owns the stolen frame and is valid always maps to that frame
   logic [PageCount-1:0] page_valid_in;
   always_comb begin
      page_valid_in = page_valid_ff;
      if (drop_victim && page_valid_ff[own_rd_ff]) page_valid_in[own_rd_ff] = 1'b0;
      if (pt_write) page_valid_in[page_ff] = 1'b1;
   end

   logic [TW-1:0] tlb_oldest_in;
   assign tlb_oldest_in = (tlb_oldest_ff == TW'(TLB_ENTRIES - 1)) ? '0 :
                          tlb_oldest_ff + TW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         tlb_count_ff <= '0;
         tlb_oldest_ff <= '0;
         page_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (used_inc) used_ff <= used_ff + CntBits'(1);
         page_valid_ff <= page_valid_in;
         if (tlb_insert) begin
            if (tlb_count_ff >= TC'(TLB_ENTRIES)) begin
               tlb_oldest_ff <= tlb_oldest_in;
            end else begin
               tlb_count_ff <= tlb_count_ff + TC'(1);
            end
         end
      end
   end

   logic [TW-1:0] tlb_wr_idx;
   logic [TW:0]   tlb_sum;
   assign tlb_sum = {1'b0, tlb_oldest_ff} + (TW+1)'(tlb_count_ff);
   assign tlb_wr_idx = (tlb_count_ff >= TC'(TLB_ENTRIES)) ? tlb_oldest_ff :
                       (tlb_sum >= (TW+1)'(TLB_ENTRIES)) ?
                       TW'(tlb_sum - (TW+1)'(TLB_ENTRIES)) : TW'(tlb_sum);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start && !busy) begin
         page_ff <= req_virtual_address[15:8];
         offset_ff <= req_virtual_address[7:0];
      end
      frame_ff <= frame_in;
      hit_ff <= hit_in; fault_ff <= fault_in; evict_ff <= evict_in; victim_ff <= victim_in;
      pf_rd_ff <= page_frame_mem[page_ff];
      own_rd_ff <= owner_mem[frame_in];
      if (pt_write) page_frame_mem[page_ff] <= frame_ff;
      if (owner_write) owner_mem[frame_ff] <= page_ff;
      if (tlb_insert) begin
         tlb_page_ff[tlb_wr_idx] <= page_ff;
         tlb_frame_ff[tlb_wr_idx] <= frame_ff;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_physical_address = {frame_ff, offset_ff};
   assign rsp_tlb_hit = hit_ff;
   assign rsp_page_fault = fault_ff;
   assign rsp_evicted = evict_ff;
   assign rsp_evicted_page = evict_ff ? victim_ff : 8'd0;
endmodule

// ===== design/tlbt_lru_cell.sv =====
// one cell of the lru chain: holds one frame number
// depends on tlbt_pkg
module tlbt_lru_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic                load_en,
   input  tlbt_pkg::frame_type load_value,
   input  tlbt_pkg::frame_type next_value,
   output tlbt_pkg::frame_type value
);
   import tlbt_pkg::*;
   frame_type value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = load_value;
      end else if (shift_en) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;
endmodule
